>>> rtl/sbsh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the SHA-256 byte stream hasher.
// No dependencies; every other file imports this package.
package sbsh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_upper_mid;
    logic [63:0] digest_lower_mid;
    logic [63:0] digest_low;
  } out_req_t;

  typedef logic [7:0][31:0] word8_t;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       start;
    logic       init;
  } core_req_t;

  typedef struct packed {
    logic   busy;
    word8_t digest;
  } core_sts_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam word8_t InitHash = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

endpackage

>>> rtl/sbsh_round.sv
`timescale 1ns / 1ps
// One SHA-256 compression round on the eight working variables.
// Depends on sbsh_pkg for the word array type and the rotate helper.
module sbsh_round
  import sbsh_pkg::*;
(
  input  word8_t      v_i,
  input  logic [31:0] k_i,
  input  logic [31:0] w_i,
  output word8_t      v_o
);

  logic [31:0] big1, ch, t1, big0, maj, t2;

  always_comb begin
    big1 = rotr32(v_i[4], 6) ^ rotr32(v_i[4], 11) ^ rotr32(v_i[4], 25);
    ch   = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    t1   = v_i[7] + big1 + ch + k_i + w_i;
    big0 = rotr32(v_i[0], 2) ^ rotr32(v_i[0], 13) ^ rotr32(v_i[0], 22);
    maj  = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t2   = big0 + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end

endmodule

>>> rtl/sbsh_core.sv
`timescale 1ns / 1ps
// Block window, message schedule and iterative compression over one shared round unit.
// Depends on sbsh_pkg and sbsh_round.
module sbsh_core
  import sbsh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_req_t req_i,
  output core_sts_t sts_o
);

  logic [511:0] win_q;
  word8_t       v_q, v_nxt, h_q;
  logic [5:0]   rnd_q;
  logic         busy_q, fin_q;
  logic [31:0]  w0, w1, w9, w14, s0, s1, w_new;
  logic         rnd_en;

  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];
  assign s0  = rotr32(w1, 7) ^ rotr32(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr32(w14, 17) ^ rotr32(w14, 19) ^ (w14 >> 10);
  assign w_new  = s1 + w9 + s0 + w0;
  assign rnd_en = busy_q && !fin_q;

  sbsh_round u_round (
    .v_i (v_q),
    .k_i (RoundK[rnd_q]),
    .w_i (w0),
    .v_o (v_nxt)
  );

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      win_q <= {win_q[503:0], req_i.data};
    end else if (rnd_en) begin
      win_q <= {win_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      v_q <= h_q;
    end else if (rnd_en) begin
      v_q <= v_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
      h_q    <= InitHash;
    end else if (req_i.init) begin
      h_q <= InitHash;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
    end else if (busy_q) begin
      if (fin_q) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b0;
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end else begin
        if (rnd_q == 6'(Rounds - 1)) begin
          fin_q <= 1'b1;
        end
        rnd_q <= rnd_q + 6'd1;
      end
    end
  end

  assign sts_o.busy   = busy_q;
  assign sts_o.digest = h_q;

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// SHA-256 hasher that takes a message one byte per request and returns the digest.
// Depends on sbsh_pkg and sbsh_core.
//
// The input channel carries one request per byte: data_byte, byte_present and last_byte.
// A request is taken at a clock edge where in_valid_i is high and in_stall_o is low.
// A byte that does not complete a 64-byte block is taken without a stall. The byte that
// completes a block starts a compression in the shared round unit: 64 rounds at one per
// cycle, then a step that folds the result into the hash words and a return to idle, with
// the input stalled throughout.
// A request with last_byte set pads the message one byte per cycle up to offset 56,
// pausing for a compression if the block fills first, appends the 8 length bytes, and
// runs one or two compressions in all before the digest is ready.
// The digest then goes into an output register as one request of four 64-bit words,
// and the hash state returns to the initial values. If the receiver holds out_stall_i
// high, the register keeps its request and a later digest waits until it is taken, with
// the input stalled; bytes of the next message are accepted until that digest is ready.
// After reset the hash words hold the initial values, the byte and bit counts are zero,
// the output register is empty, and the block is ready for the first byte.
module sha256_byte_stream_hasher
  import sbsh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COMP  = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bitcnt_q, bitcnt_d;
  logic        ending_q, ending_d;
  logic        first_q, first_d;
  logic        out_valid_q;
  out_req_t    out_q;
  logic        out_load;
  core_req_t   core_req;
  core_sts_t   core_sts;

  sbsh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (core_req),
    .sts_o  (core_sts)
  );

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    bitcnt_d = bitcnt_q;
    ending_d = ending_q;
    first_d  = first_q;
    out_load = 1'b0;
    core_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.byte_present) begin
            core_req.load = 1'b1;
            core_req.data = in_data_i.data_byte;
            bitcnt_d      = bitcnt_q + 64'd8;
            fill_d        = fill_q + 6'd1;
            core_req.start = (fill_d == '0);
          end
          if (in_data_i.last_byte) begin
            ending_d = 1'b1;
            first_d  = 1'b1;
          end
          if (core_req.start) begin
            state_d = S_COMP;
          end else if (in_data_i.last_byte) begin
            state_d = S_PAD;
          end
        end
      end
      S_COMP: begin
        if (!core_sts.busy) begin
          state_d = ending_q ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        core_req.load = 1'b1;
        core_req.data = first_q ? PadByte : 8'h00;
        first_d       = 1'b0;
        fill_d        = fill_q + 6'd1;
        if (fill_d == '0) begin
          core_req.start = 1'b1;
          state_d        = S_COMP;
        end else if (fill_d == 6'(LenOffset)) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        core_req.load = 1'b1;
        core_req.data = bitcnt_q[63:56];
        bitcnt_d      = {bitcnt_q[55:0], bitcnt_q[63:56]};
        fill_d        = fill_q + 6'd1;
        if (fill_d == '0) begin
          core_req.start = 1'b1;
          state_d        = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!core_sts.busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load      = 1'b1;
          core_req.init = 1'b1;
          bitcnt_d      = '0;
          fill_d        = '0;
          ending_d      = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      bitcnt_q    <= '0;
      ending_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      bitcnt_q <= bitcnt_d;
      ending_q <= ending_d;
      first_q  <= first_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.digest_high      <= {core_sts.digest[0], core_sts.digest[1]};
      out_q.digest_upper_mid <= {core_sts.digest[2], core_sts.digest[3]};
      out_q.digest_lower_mid <= {core_sts.digest[4], core_sts.digest[5]};
      out_q.digest_low       <= {core_sts.digest[6], core_sts.digest[7]};
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_sts.busy |-> (state_q == S_COMP || state_q == S_FINAL))
    else $error("round unit busy outside a compression wait");

  a_len_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN) |-> (fill_q[5:3] == 3'd7))
    else $error("length bytes placed outside the last eight block bytes");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_q || !out_stall_i)) |=> (out_valid_q && state_q == S_IDLE))
    else $error("digest not loaded into the output register");

  a_pad_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAD || state_q == S_LEN || state_q == S_FINAL) |-> ending_q)
    else $error("padding without a finishing message");

endmodule

>>> tb/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sha256_byte_stream_hasher: byte streams in, digests checked.
// Depends on sbsh_pkg and the RTL; it keeps its own SHA-256 predictor of the expected digests.
module sha256_byte_stream_hasher_tb;
  import sbsh_pkg::*;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned TailCycles = 300;
  localparam int unsigned PhaseLen   = 160;
  localparam int unsigned HoldStart  = 500;
  localparam int unsigned HoldCycles = 3000;

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] ShaInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;

  in_req_t     pending_q [$];
  out_req_t    digest_q [$];
  int unsigned taken_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_armed = 1'b1;
  int unsigned err_cnt = 0;
  idle_mode_e  idle_mode;

  logic [31:0] hash_words [8];
  logic [7:0]  block_bytes [64];
  int unsigned fill_cnt;
  logic [63:0] bit_len;

  sha256_byte_stream_hasher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign idle_mode = idle_mode_e'(2'((taken_cnt / PhaseLen) % 4));

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void clear_hash_state();
    for (int i = 0; i < 8; i++) hash_words[i] = ShaInit[i];
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    fill_cnt = 0;
    bit_len = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int i = 0; i < 64; i++) begin
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ShaK[i] + w[i];
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] = hash_words[i] + v[i];
  endfunction

  // Updates the predicted hash state with one accepted request.
  function automatic void absorb_request(in_req_t r);
    int unsigned pos;
    out_req_t    dg;
    if (r.byte_present) begin
      block_bytes[fill_cnt] = r.data_byte;
      bit_len = bit_len + 64'd8;
      fill_cnt = (fill_cnt + 1) % 64;
      if (fill_cnt == 0) sha_compress();
    end
    if (r.last_byte) begin
      pos = fill_cnt;
      block_bytes[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        sha_compress();
        pos = 0;
      end
      while (pos < 56) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
      sha_compress();
      dg.digest_high      = {hash_words[0], hash_words[1]};
      dg.digest_upper_mid = {hash_words[2], hash_words[3]};
      dg.digest_lower_mid = {hash_words[4], hash_words[5]};
      dg.digest_low       = {hash_words[6], hash_words[7]};
      digest_q.push_back(dg);
      clear_hash_state();
    end
  endfunction

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 61;
      IDLE_BOTH: return $urandom_range(99) < 34;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 61;
      IDLE_BOTH: return $urandom_range(99) < 34;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic void check_word(string name, logic [63:0] exp_w, logic [63:0] act_w);
    if (act_w !== exp_w) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_w, act_w);
      err_cnt++;
    end
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        absorb_request(in_data);
        taken_cnt <= taken_cnt + 1;
      end
      if (pending_q.size() != 0 && !sender_rests()) begin
        in_valid <= 1'b1;
        in_data  <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the output register fills and the input side backs up.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && taken_cnt >= HoldStart) begin
      hold_left  <= HoldCycles;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    out_req_t exp_d;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest: actual %h", out_data);
          err_cnt++;
        end else begin
          exp_d = digest_q.pop_front();
          check_word("digest_high", exp_d.digest_high, out_data.digest_high);
          check_word("digest_upper_mid", exp_d.digest_upper_mid, out_data.digest_upper_mid);
          check_word("digest_lower_mid", exp_d.digest_lower_mid, out_data.digest_lower_mid);
          check_word("digest_low", exp_d.digest_low, out_data.digest_low);
        end
      end
      out_stall <= (hold_left != 0) || receiver_rests();
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_item(logic [7:0] data, logic present, logic last);
    in_req_t r;
    r.data_byte    = data;
    r.byte_present = present;
    r.last_byte    = last;
    pending_q.push_back(r);
  endtask

  initial begin
    int unsigned boundary_len [10];
    int unsigned len;
    bit          byteless_end;

    boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    clear_hash_state();

    push_item(8'ha5, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h5a, 1'b0, 1'b1);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'h7f, 1'b1, 1'b1);

    while (pending_q.size() < 1250) begin
      case ($urandom_range(9))
        0:       len = boundary_len[$urandom_range(9)];
        1:       len = $urandom_range(200, 64);
        default: len = $urandom_range(40, 0);
      endcase
      byteless_end = (len == 0) || ($urandom_range(1) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 8) push_item(8'($urandom), 1'b0, 1'b0);
        push_item(8'($urandom), 1'b1, (i == len - 1) && !byteless_end);
      end
      if (byteless_end) push_item(8'($urandom), 1'b0, 1'b1);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
